// ===== design/csq_pkg.sv =====
// ============================================================================
// csq_pkg
// Shared types and constants for the counting semaphore with wait queue.
// ============================================================================
`default_nettype none

package csq_pkg;

    // Default sizes
    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int THREAD_ID_BITS_DEF = 8;

    // Counter
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes
    localparam logic FUNC_WAIT   = 1'b0;
    localparam logic FUNC_SIGNAL = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_INCREMENTED = 3'd2,
        ST_WOKEN       = 3'd3,
        ST_FULL        = 3'd4,
        ST_SATURATED   = 3'd5
    } status_t;

    // Control sequencer states
    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

endpackage

`default_nettype wire

// ===== design/csq_req_if.sv =====
// ============================================================================
// csq_req_if
// Operation channel: valid/ready with function code and thread id.
// ============================================================================
`default_nettype none

interface csq_req_if #(
    parameter int ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic               func;
    logic [ID_BITS-1:0] thread_id;

    modport source (output valid, output func, output thread_id, input ready);
    modport sink   (input valid, input func, input thread_id, output ready);
endinterface

`default_nettype wire

// ===== design/csq_rsp_if.sv =====
// ============================================================================
// csq_rsp_if
// Result channel: valid/ready with prior count, status and woken thread.
// ============================================================================
`default_nettype none

interface csq_rsp_if #(
    parameter int ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [csq_pkg::COUNT_W-1:0] prior_count;
    csq_pkg::status_t            status;
    logic [ID_BITS-1:0]          woken_thread;

    modport source (output valid, output prior_count, output status,
                    output woken_thread, input ready);
    modport sink   (input valid, input prior_count, input status,
                    input woken_thread, output ready);
endinterface

`default_nettype wire

// ===== design/csq_ram.sv =====
// ============================================================================
// csq_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/counting_semaphore_wait_queue_top.sv =====
// ============================================================================
// counting_semaphore_wait_queue_top
// Counting semaphore with a FIFO queue of blocked thread ids.
// ============================================================================
// Each request transfer is a wait or a signal from one thread and yields
// exactly one response transfer with the count as it stood before the
// operation. A signal that wakes a waiter passes through the fetch state,
// where the oldest id comes out of the wait-queue RAM, whose read data is
// registered, in the cycle after the request is taken. A new request is
// taken while the previous response waits, as long as that response is
// consumed in the same cycle. Writing cfg_wdata with cfg_we loads the
// counter and leaves the queue untouched. The queue RAM needs no clearing
// after reset; head, tail and occupancy start at zero.
// ============================================================================
`default_nettype none

module counting_semaphore_wait_queue_top #(
    parameter int QUEUE_DEPTH    = csq_pkg::QUEUE_DEPTH_DEF,
    parameter int THREAD_ID_BITS = csq_pkg::THREAD_ID_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [csq_pkg::COUNT_W-1:0] cfg_wdata,
    csq_req_if.sink                          req,
    csq_rsp_if.source                        rsp
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

    // State
    logic [csq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [OCC_W-1:0]            occ_reg, occ_next;
    csq_pkg::state_t             state_reg, state_next;

    // Output register
    logic                        out_valid_reg;
    logic [csq_pkg::COUNT_W-1:0] prior_reg;
    csq_pkg::status_t            status_reg, status_next;
    logic [THREAD_ID_BITS-1:0]   woken_reg;

    logic                      in_fire;
    logic                      cnt_zero;
    logic                      q_full;
    logic                      q_empty;
    logic                      push;
    logic                      pop;
    logic [THREAD_ID_BITS-1:0] ram_rdata;

    assign in_fire  = req.valid && req.ready;
    assign cnt_zero = (count_reg == '0);
    assign q_full   = (occ_reg == OCC_FULL);
    assign q_empty  = (occ_reg == '0);

    // Operation decode
    always_comb
    begin
        count_next  = count_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        occ_next    = occ_reg;
        status_next = csq_pkg::ST_GRANTED;
        push        = 1'b0;
        pop         = 1'b0;
        case (req.func)
            csq_pkg::FUNC_WAIT:
            begin
                if (!cnt_zero)
                begin
                    count_next  = count_reg - 1'b1;
                    status_next = csq_pkg::ST_GRANTED;
                end
                else if (!q_full)
                begin
                    push        = 1'b1;
                    tail_next   = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
                    occ_next    = occ_reg + 1'b1;
                    status_next = csq_pkg::ST_QUEUED;
                end
                else
                begin
                    status_next = csq_pkg::ST_FULL;
                end
            end
            csq_pkg::FUNC_SIGNAL:
            begin
                if (cnt_zero && !q_empty)
                begin
                    pop         = 1'b1;
                    head_next   = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                    occ_next    = occ_reg - 1'b1;
                    status_next = csq_pkg::ST_WOKEN;
                end
                else if (count_reg == csq_pkg::COUNT_MAX)
                begin
                    status_next = csq_pkg::ST_SATURATED;
                end
                else
                begin
                    count_next  = count_reg + 1'b1;
                    status_next = csq_pkg::ST_INCREMENTED;
                end
            end
            default:
            begin
                status_next = csq_pkg::ST_GRANTED;
            end
        endcase
    end

    // Wait-queue storage; read port always points at the head
    csq_ram #(
        .WIDTH (THREAD_ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (in_fire && push),
        .waddr (tail_reg),
        .wdata (req.thread_id),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csq_pkg::S_IDLE:
            begin
                if (in_fire && pop)
                begin
                    state_next = csq_pkg::S_FETCH;
                end
            end
            csq_pkg::S_FETCH:
            begin
                state_next = csq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = csq_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        case (state_reg)
            csq_pkg::S_IDLE:  req.ready = !out_valid_reg || rsp.ready;
            csq_pkg::S_FETCH: req.ready = 1'b0;
            default:          req.ready = 1'b0;
        endcase
    end

    // Semaphore state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            occ_reg   <= '0;
            state_reg <= csq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            else if (in_fire)
            begin
                count_reg <= count_next;
            end
            if (in_fire)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                occ_reg  <= occ_next;
            end
        end
    end

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= !pop;
        end
        else if (state_reg == csq_pkg::S_FETCH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Response payload; woken id lands from the RAM in the fetch state
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            prior_reg  <= count_reg;
            status_reg <= status_next;
            woken_reg  <= '0;
        end
        else if (state_reg == csq_pkg::S_FETCH)
        begin
            woken_reg <= ram_rdata;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.prior_count  = prior_reg;
    assign rsp.status       = status_reg;
    assign rsp.woken_thread = woken_reg;

    // Checks
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_FULL)
        else $error("queue occupancy above depth");

    a_fetch_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == csq_pkg::S_FETCH) |-> !out_valid_reg)
        else $error("fetch while a response is still held");

    a_pop_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pop) |=> (state_reg == csq_pkg::S_FETCH) && !req.ready)
        else $error("wake did not enter fetch");

    a_woken_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != csq_pkg::ST_WOKEN)) |-> (woken_reg == '0))
        else $error("woken id set without a wake");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_we && !in_fire) |=> $stable(count_reg))
        else $error("count changed without a transfer or load");

endmodule

`default_nettype wire
